// ----- hw/rtl/hpt_pkg.sv -----
// Shared types, widths and constants for the height PID throttle block.
`timescale 1ns / 1ps

package hpt_pkg;

    // Field and term widths
    localparam int HEIGHT_W   = 15;
    localparam int GAIN_W     = 20;
    localparam int BASE_W     = 16;
    localparam int ERR_W      = HEIGHT_W + 1;
    localparam int DERR_W     = ERR_W + 1;
    localparam int PTERM_W    = GAIN_W + 1 + ERR_W;
    localparam int DTERM_W    = GAIN_W + 1 + DERR_W;
    localparam int INTEG_W    = 48;
    localparam int SUM_W      = INTEG_W + 2;
    localparam int FRAC_BITS  = 12;
    localparam int PID_W      = 16;
    localparam int THR_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] TARGET_RST = HEIGHT_W'(6000);
    localparam logic [GAIN_W-1:0]   KP_RST     = GAIN_W'(1155);
    localparam logic [GAIN_W-1:0]   KI_RST     = '0;
    localparam logic [GAIN_W-1:0]   KD_RST     = '0;
    localparam logic [BASE_W-1:0]   BASE_RST   = BASE_W'(34700);

    // Apply test: VALID_BASE - pid < VALID_LIMIT, i.e. pid > VALID_BASE - VALID_LIMIT
    localparam int VALID_BASE  = 34700;
    localparam int VALID_LIMIT = 40000;
    localparam logic signed [PID_W-1:0] PID_FLOOR = PID_W'(VALID_BASE - VALID_LIMIT);

    // Register index map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_KD     = 3'd3,
        REG_BASE   = 3'd4
    } cfg_reg_t;

    // Final output values of one request
    typedef struct packed {
        logic signed [PID_W-1:0] pid;
        logic [THR_W-1:0]        thr;
        logic                    apply;
    } result_t;

endpackage

// ----- hw/rtl/hpt_mix.sv -----
// Term sum, truncation toward zero and output saturation.
`timescale 1ns / 1ps

module hpt_mix
    import hpt_pkg::*;
(
    input  logic signed [PTERM_W-1:0] p_term,
    input  logic signed [INTEG_W-1:0] i_term,
    input  logic signed [DTERM_W-1:0] d_term,
    input  logic [BASE_W-1:0]         base,
    output result_t                   res
);

    localparam int QUO_W = SUM_W - FRAC_BITS;
    localparam int TSUM_W = PID_W + 2;

    logic signed [SUM_W-1:0]  sum;
    logic signed [QUO_W-1:0]  quo;
    logic                     round_up;
    logic signed [PID_W-1:0]  pid;
    logic signed [TSUM_W-1:0] thr_sum;

    // Q.12 sum of the three terms
    assign sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

    // Floor shift, then bump negatives with a fraction to truncate toward zero
    assign round_up = sum[SUM_W-1] && (|sum[FRAC_BITS-1:0]);
    assign quo = QUO_W'(sum >>> FRAC_BITS) + QUO_W'({1'b0, round_up});

    // Saturate to signed 16 bits
    always_comb
    begin
        if (quo > QUO_W'(32767))
        begin
            pid = 16'sh7FFF;
        end
        else if (quo < -QUO_W'(32768))
        begin
            pid = -16'sh8000;
        end
        else
        begin
            pid = PID_W'(quo);
        end
    end

    // Throttle = base + pid, clamped to 0..65535
    assign thr_sum = $signed({2'b00, base}) + TSUM_W'(pid);

    always_comb
    begin
        res.pid = pid;
        if (thr_sum[TSUM_W-1])
        begin
            res.thr = '0;
        end
        else if (thr_sum[TSUM_W-2])
        begin
            res.thr = '1;
        end
        else
        begin
            res.thr = thr_sum[THR_W-1:0];
        end
        res.apply = (pid > PID_FLOOR);
    end

endmodule

// ----- hw/rtl/height_pid_throttle.sv -----
// Top level of the height PID throttle controller.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel takes one height sample per request (s_tdata[14:0]).
//   m_* channel returns one result per sample: m_tdata[15:0] signed pid
//   output, m_tdata[31:16] throttle command, m_tuser apply flag.
//   cfg_* is a write-only register port (index 0..4, others ignored);
//   write it only while no sample is in flight.
// Timing:
//   Four register stages: input, products, integrator, result.
//   A sample passes through the input, product, integrator and result
//   registers in turn. One sample per cycle sustained while m_tready
//   holds high; the integrator update is a single saturating add per cycle.
// Reset:
//   rst_n clears the pipeline, the integrator and the previous error and
//   loads the register defaults (target 6000, kp 1155, ki 0, kd 0,
//   base 34700).
// Backpressure:
//   Each stage holds while the one after it is full and stalled; bubbles
//   collapse, so s_tready drops only when all four stages are occupied.

module height_pid_throttle
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Height sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [14:0] measured_height, [15] zero
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] pid_output, [31:16] throttle_command
    output logic                  m_tuser    // [0] throttle_valid
);

    // Configuration registers
    logic [HEIGHT_W-1:0] target_reg;
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   ki_reg;
    logic [GAIN_W-1:0]   kd_reg;
    logic [BASE_W-1:0]   base_reg;

    // Pipeline control
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic adv0, adv1, adv2, adv3;

    // Stage payloads and controller state
    logic [HEIGHT_W-1:0]        height_reg;
    logic signed [PTERM_W-1:0]  p1_reg, p2_reg;
    logic signed [PTERM_W-1:0]  i1_reg;
    logic signed [DTERM_W-1:0]  d1_reg, d2_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    result_t                    res_reg;

    logic signed [ERR_W-1:0]    err;
    logic signed [DERR_W-1:0]   derr;
    logic signed [INTEG_W:0]    integ_wide;
    result_t                    res;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            kp_reg     <= KP_RST;
            ki_reg     <= KI_RST;
            kd_reg     <= KD_RST;
            base_reg   <= BASE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TARGET: target_reg <= cfg_wdata[HEIGHT_W-1:0];
                REG_KP:     kp_reg     <= cfg_wdata;
                REG_KI:     ki_reg     <= cfg_wdata;
                REG_KD:     kd_reg     <= cfg_wdata;
                REG_BASE:   base_reg   <= cfg_wdata[BASE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Stage advance: a stage moves when empty or when its successor moves
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign s_tready = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv0) v0_reg <= s_tvalid;
            if (adv1) v1_reg <= v0_reg;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Stage 0: capture sample
    always_ff @(posedge clk)
    begin
        if (adv0 && s_tvalid)
        begin
            height_reg <= s_tdata[HEIGHT_W-1:0];
        end
    end

    // Stage 1: error, derivative difference and the three products
    assign err  = $signed({1'b0, target_reg}) - $signed({1'b0, height_reg});
    assign derr = DERR_W'(err) - DERR_W'(prev_err_reg);

    always_ff @(posedge clk)
    begin
        if (adv1 && v0_reg)
        begin
            p1_reg <= PTERM_W'($signed({1'b0, kp_reg})) * PTERM_W'(err);
            i1_reg <= PTERM_W'($signed({1'b0, ki_reg})) * PTERM_W'(err);
            d1_reg <= DTERM_W'($signed({1'b0, kd_reg})) * DTERM_W'(derr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (adv1 && v0_reg)
        begin
            prev_err_reg <= err;
        end
    end

    // Stage 2: saturating integrator
    assign integ_wide = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(i1_reg);

    always_comb
    begin
        if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1])
        begin
            integ_next = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                             : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_wide[INTEG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (adv2 && v1_reg)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            p2_reg <= p1_reg;
            d2_reg <= d1_reg;
        end
    end

    // Stage 3: sum, scale and saturate into the result register
    hpt_mix u_mix (
        .p_term (p2_reg),
        .i_term (integ_reg),
        .d_term (d2_reg),
        .base   (base_reg),
        .res    (res)
    );

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {res_reg.thr, res_reg.pid};
    assign m_tuser  = res_reg.apply;

endmodule
